### src/dgec_pkg.sv
// Shared types and constants for the dial gesture and encoder command unit.
`timescale 1ns / 1ps
package dgec_pkg;

  localparam int unsigned RegCount = 6;
  localparam int unsigned AddrW    = 5;
  localparam int unsigned DataW    = 32;

  // Input word command codes
  typedef enum logic [1:0] {
    CMD_TICK = 2'd0,
    CMD_EDGE = 2'd1,
    CMD_DONE = 2'd2
  } item_cmd_e;

  // Result command codes
  typedef enum logic [2:0] {
    DC_NONE       = 3'd0,
    DC_MUTE       = 3'd1,
    DC_PLAY_PAUSE = 3'd2,
    DC_STOP       = 3'd3,
    DC_VOL_UP     = 3'd4,
    DC_VOL_DOWN   = 3'd5,
    DC_NEXT       = 3'd6,
    DC_PREVIOUS   = 3'd7
  } dial_cmd_e;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_EDGE_MASK          = 3'd0,
    REG_PRESS_PATTERN      = 3'd1,
    REG_RELEASE_PATTERN    = 3'd2,
    REG_CLICK_TICKS        = 3'd3,
    REG_SECOND_PRESS_TICKS = 3'd4,
    REG_HOLD_TICKS         = 3'd5
  } reg_idx_e;

  localparam logic [7:0] EdgeMaskRst     = 8'd15;
  localparam logic [7:0] PressPatRst     = 8'd12;
  localparam logic [7:0] ReleasePatRst   = 8'd3;
  localparam logic [7:0] ClickTicksRst   = 8'd30;
  localparam logic [7:0] SecondTicksRst  = 8'd30;
  localparam logic [7:0] HoldTicksRst    = 8'd100;

  typedef struct packed {
    logic [7:0] edge_mask;
    logic [7:0] press_pattern;
    logic [7:0] release_pattern;
    logic [7:0] click_ticks;
    logic [7:0] second_press_ticks;
    logic [7:0] hold_ticks;
  } cfg_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic       switch_level;
    logic       enc_clk;
    logic       enc_dir;
  } item_t;

endpackage

### src/dial_gesture_and_encoder_commands_unit.sv
// Top level of the media dial gesture and encoder command unit.
// Path: an accepted word is held in the input register, then retired by the state
// update into the result register once that register is empty or being drained.
// Throughput: one word per cycle while results are taken; the result and input
// registers together let a new word in while a finished result waits to be taken.
// Reset: rst_ni at once clears gesture state and steps, presets history and registers.
`timescale 1ns / 1ps
module dial_gesture_and_encoder_commands_unit import dgec_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  // Input words
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [1:0]       cmd_i,
  input  logic             switch_level_i,
  input  logic             enc_clk_i,
  input  logic             enc_dir_i,
  // Result words
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [2:0]       command_o,
  output logic             track_mode_o,
  // Configuration port
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready
);

  cfg_t  cfg;
  item_t in_item;
  item_t stage_item;
  logic  stage_valid;
  logic  take;

  // Bundle the input word fields
  assign in_item = '{cmd: cmd_i, switch_level: switch_level_i,
                     enc_clk: enc_clk_i, enc_dir: enc_dir_i};

  // Configuration registers; the user must write them only while no word is in flight (not enforced here)
  dgec_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Hold the accepted word until the core can retire it into the result
  // register; advance whenever the result register is empty or being drained.
  dgec_in_stage u_in (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .item_i       (in_item),
    .take_i       (take),
    .item_valid_o (stage_valid),
    .item_o       (stage_item)
  );

  // Tick, edge and report-done handling in one pass: the timer, history,
  // gesture machine and step drain all resolve before the result register.
  dgec_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .item_valid_i (stage_valid),
    .item_i       (stage_item),
    .take_o       (take),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .command_o    (command_o),
    .track_mode_o (track_mode_o)
  );

endmodule

### src/dgec_cfg_regs.sv
// APB configuration register file for the dial unit.
`timescale 1ns / 1ps
module dgec_cfg_regs import dgec_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready,
  output cfg_t             cfg_o
);

  cfg_t     cfg_q;
  reg_idx_e idx;
  logic     wr_en;

  assign idx    = reg_idx_e'(paddr[AddrW-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.edge_mask          <= EdgeMaskRst;
      cfg_q.press_pattern      <= PressPatRst;
      cfg_q.release_pattern    <= ReleasePatRst;
      cfg_q.click_ticks        <= ClickTicksRst;
      cfg_q.second_press_ticks <= SecondTicksRst;
      cfg_q.hold_ticks         <= HoldTicksRst;
    end else if (wr_en) begin
      case (idx)
        REG_EDGE_MASK:          cfg_q.edge_mask          <= pwdata[7:0];
        REG_PRESS_PATTERN:      cfg_q.press_pattern      <= pwdata[7:0];
        REG_RELEASE_PATTERN:    cfg_q.release_pattern    <= pwdata[7:0];
        REG_CLICK_TICKS:        cfg_q.click_ticks        <= pwdata[7:0];
        REG_SECOND_PRESS_TICKS: cfg_q.second_press_ticks <= pwdata[7:0];
        REG_HOLD_TICKS:         cfg_q.hold_ticks         <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_EDGE_MASK:          prdata = {24'd0, cfg_q.edge_mask};
      REG_PRESS_PATTERN:      prdata = {24'd0, cfg_q.press_pattern};
      REG_RELEASE_PATTERN:    prdata = {24'd0, cfg_q.release_pattern};
      REG_CLICK_TICKS:        prdata = {24'd0, cfg_q.click_ticks};
      REG_SECOND_PRESS_TICKS: prdata = {24'd0, cfg_q.second_press_ticks};
      REG_HOLD_TICKS:         prdata = {24'd0, cfg_q.hold_ticks};
      default:                prdata = '0;
    endcase
  end

endmodule

### src/dgec_in_stage.sv
// Input register stage that captures one word per cycle while empty or while its word moves on.
`timescale 1ns / 1ps
module dgec_in_stage import dgec_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  item_t item_i,
  input  logic  take_i,
  output logic  item_valid_o,
  output item_t item_o
);

  logic  valid_q;
  item_t item_q;

  // Accept when empty or when the held word moves on this cycle
  assign in_ready_o   = !valid_q || take_i;
  assign item_valid_o = valid_q;
  assign item_o       = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= item_i;
    end
  end

endmodule

### src/dgec_core.sv
// Gesture machine, encoder step counter and result register.
`timescale 1ns / 1ps
module dgec_core import dgec_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  logic       item_valid_i,
  input  item_t      item_i,
  output logic       take_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [2:0] command_o,
  output logic       track_mode_o
);

  typedef enum logic [2:0] {
    GS_IDLE       = 3'd0,
    GS_PRESS      = 3'd1,
    GS_DBL_BREAK  = 3'd2,
    GS_DBL_CLICK  = 3'd3,
    GS_HOLD       = 3'd4,
    GS_BREAK_WAIT = 3'd5
  } gest_e;

  gest_e              gest_q, gest_d;
  logic [7:0]         hist_q, hist_d;
  logic [7:0]         timer_q, timer_d;
  logic               mode_q, mode_d;
  logic [1:0]         pins_q, pins_d;
  logic signed [7:0]  steps_q, steps_d;
  logic               busy_q, busy_d;
  logic               out_valid_q;
  dial_cmd_e          command_q, command_d;
  logic               track_q;

  assign take_o       = item_valid_i && (!out_valid_q || out_ready_i);
  assign out_valid_o  = out_valid_q;
  assign command_o    = command_q;
  assign track_mode_o = track_q;

  always_comb begin
    logic [7:0] timer_dec;
    logic [7:0] hist_m;
    logic       press;
    logic       release_n;
    logic [1:0] pins;

    gest_d    = gest_q;
    hist_d    = hist_q;
    timer_d   = timer_q;
    mode_d    = mode_q;
    pins_d    = pins_q;
    steps_d   = steps_q;
    busy_d    = busy_q;
    command_d = DC_NONE;

    timer_dec = (timer_q != 8'd0) ? timer_q - 8'd1 : timer_q;
    hist_m    = {hist_q[6:0], item_i.switch_level} & cfg_i.edge_mask;
    press     = hist_m == cfg_i.press_pattern;
    release_n = hist_m == cfg_i.release_pattern;
    pins      = {item_i.enc_clk, item_i.enc_dir};

    case (item_cmd_e'(item_i.cmd))
      CMD_TICK: begin
        timer_d = timer_dec;
        hist_d  = {hist_q[6:0], item_i.switch_level};
        case (gest_q)
          GS_IDLE: begin
            if (press) begin
              gest_d  = GS_PRESS;
              timer_d = cfg_i.click_ticks;
            end
          end
          GS_PRESS: begin
            if (timer_dec == 8'd0) begin
              if (!busy_q) begin
                gest_d    = GS_HOLD;
                timer_d   = cfg_i.hold_ticks;
                command_d = mode_q ? DC_PLAY_PAUSE : DC_MUTE;
                busy_d    = 1'b1;
              end
            end else if (release_n) begin
              gest_d  = GS_DBL_BREAK;
              timer_d = cfg_i.second_press_ticks;
            end
          end
          GS_DBL_BREAK: begin
            if (timer_dec == 8'd0) begin
              gest_d = GS_IDLE;
            end else if (press) begin
              gest_d = GS_DBL_CLICK;
            end
          end
          GS_DBL_CLICK: begin
            mode_d  = !mode_q;
            timer_d = cfg_i.hold_ticks;
            gest_d  = GS_BREAK_WAIT;
          end
          GS_HOLD: begin
            if (timer_dec == 8'd0) begin
              if (!busy_q) begin
                command_d = mode_q ? DC_STOP : DC_PLAY_PAUSE;
                gest_d    = GS_BREAK_WAIT;
                busy_d    = 1'b1;
              end
            end else if (release_n) begin
              gest_d = GS_IDLE;
            end
          end
          GS_BREAK_WAIT: begin
            if (release_n) begin
              gest_d = GS_IDLE;
            end
          end
          default: gest_d = GS_IDLE;
        endcase
        // Drain one pending step when no report is out
        if (!busy_d) begin
          if (steps_q > 8'sd0) begin
            steps_d   = steps_q - 8'sd1;
            command_d = mode_d ? DC_NEXT : DC_VOL_UP;
            busy_d    = 1'b1;
          end else if (steps_q < 8'sd0) begin
            steps_d   = steps_q + 8'sd1;
            command_d = mode_d ? DC_PREVIOUS : DC_VOL_DOWN;
            busy_d    = 1'b1;
          end
        end
      end
      CMD_EDGE: begin
        pins_d = pins;
        if (pins_q == 2'b01 && pins == 2'b10) begin
          steps_d = (steps_q < -8'sd126) ? -8'sd127 : steps_q - 8'sd1;
        end else if (pins_q == 2'b00 && pins == 2'b11) begin
          steps_d = (steps_q > 8'sd126) ? 8'sd127 : steps_q + 8'sd1;
        end
      end
      CMD_DONE: busy_d = 1'b0;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gest_q      <= GS_IDLE;
      hist_q      <= 8'hFF;
      timer_q     <= 8'd0;
      mode_q      <= 1'b0;
      pins_q      <= 2'b00;
      steps_q     <= 8'sd0;
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
      command_q   <= DC_NONE;
      track_q     <= 1'b0;
    end else if (take_o) begin
      gest_q      <= gest_d;
      hist_q      <= hist_d;
      timer_q     <= timer_d;
      mode_q      <= mode_d;
      pins_q      <= pins_d;
      steps_q     <= steps_d;
      busy_q      <= busy_d;
      out_valid_q <= 1'b1;
      command_q   <= command_d;
      track_q     <= mode_d;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

endmodule

### src/dgec_checker.sv
// Port-level checks for the dial unit, bound to the top level.
`timescale 1ns / 1ps
module dgec_checker import dgec_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [2:0] command_o,
  input logic       track_mode_o
);

  // Drop input ready only when the result side is stalled
  a_ready_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i))
    else $error("input stalled while result side free");

  // Volume and mute reports belong to volume mode
  a_vol_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (command_o == DC_VOL_UP || command_o == DC_VOL_DOWN ||
                     command_o == DC_MUTE)) |-> !track_mode_o)
    else $error("volume command reported in track mode");

  // Track and stop reports belong to track mode
  a_trk_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (command_o == DC_NEXT || command_o == DC_PREVIOUS ||
                     command_o == DC_STOP)) |-> track_mode_o)
    else $error("track command reported in volume mode");

  // Hold a stalled result word
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=>
      (out_valid_o && $stable(command_o) && $stable(track_mode_o)))
    else $error("stalled result word changed");

endmodule

bind dial_gesture_and_encoder_commands_unit dgec_checker u_dgec_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_ready_o   (in_ready_o),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .command_o    (command_o),
  .track_mode_o (track_mode_o)
);

### verif/tb_dial_gesture_and_encoder_commands_unit.sv
// Self-checking testbench for the dial gesture and encoder command unit.
`timescale 1ns / 1ps
module tb_dial_gesture_and_encoder_commands_unit;
  import dgec_pkg::*;

  // Command code that the block must ignore; it has no member in item_cmd_e.
  localparam logic [1:0] CmdUnknown = 2'd3;
  localparam int         HoldOffLen = 120;

  typedef enum logic [2:0] {
    GS_IDLE         = 3'd0,
    GS_PRESSED      = 3'd1,
    GS_RELEASED     = 3'd2,
    GS_DOUBLE       = 3'd3,
    GS_HOLDING      = 3'd4,
    GS_WAIT_RELEASE = 3'd5
  } gesture_e;

  typedef struct packed {
    dial_cmd_e command;
    logic      track_mode;
  } dial_result_t;

  // One row of the directed sequence. Rows with typed set carry their own result;
  // the others are checked against the gesture/encoder predictor.
  typedef struct packed {
    logic [1:0] cmd;
    logic       lvl;
    logic       ck;
    logic       dr;
    logic       typed;
    dial_cmd_e  exp_cmd;
    logic       exp_mode;
  } dir_row_t;

  localparam dir_row_t DirectedRows [23] = '{
    // Idle after reset: released switch, nothing pending.
    '{CMD_TICK,   1'b1, 1'b0, 1'b0, 1'b1, DC_NONE,     1'b0},
    // Unknown code with every payload bit high changes nothing.
    '{CmdUnknown, 1'b1, 1'b1, 1'b1, 1'b1, DC_NONE,     1'b0},
    // One detent clockwise: pins 00 then 11.
    '{CMD_EDGE,   1'b0, 1'b0, 1'b0, 1'b1, DC_NONE,     1'b0},
    '{CMD_EDGE,   1'b0, 1'b1, 1'b1, 1'b1, DC_NONE,     1'b0},
    '{CMD_TICK,   1'b1, 1'b0, 1'b0, 1'b1, DC_VOL_UP,   1'b0},
    // One detent counter-clockwise: pins 01 then 10.
    '{CMD_EDGE,   1'b0, 1'b0, 1'b1, 1'b1, DC_NONE,     1'b0},
    '{CMD_EDGE,   1'b1, 1'b1, 1'b0, 1'b1, DC_NONE,     1'b0},
    // Report still busy: the step stays pending.
    '{CMD_TICK,   1'b1, 1'b0, 1'b0, 1'b1, DC_NONE,     1'b0},
    '{CMD_DONE,   1'b0, 1'b0, 1'b0, 1'b1, DC_NONE,     1'b0},
    '{CMD_TICK,   1'b1, 1'b0, 1'b0, 1'b1, DC_VOL_DOWN, 1'b0},
    '{CMD_DONE,   1'b1, 1'b1, 1'b1, 1'b1, DC_NONE,     1'b0},
    // Double click at reset patterns: press, release, press, then the toggle.
    '{CMD_TICK,   1'b0, 1'b0, 1'b0, 1'b0, DC_NONE,     1'b0},
    '{CMD_TICK,   1'b0, 1'b1, 1'b0, 1'b0, DC_NONE,     1'b0},
    '{CMD_TICK,   1'b1, 1'b0, 1'b1, 1'b0, DC_NONE,     1'b0},
    '{CMD_TICK,   1'b1, 1'b1, 1'b1, 1'b0, DC_NONE,     1'b0},
    '{CMD_TICK,   1'b0, 1'b0, 1'b0, 1'b0, DC_NONE,     1'b0},
    '{CMD_TICK,   1'b0, 1'b0, 1'b0, 1'b0, DC_NONE,     1'b0},
    '{CMD_TICK,   1'b1, 1'b0, 1'b0, 1'b0, DC_NONE,     1'b0},
    '{CMD_TICK,   1'b1, 1'b0, 1'b0, 1'b0, DC_NONE,     1'b0},
    // A detent in track mode turns into a next-track report.
    '{CMD_EDGE,   1'b0, 1'b0, 1'b0, 1'b0, DC_NONE,     1'b0},
    '{CMD_EDGE,   1'b0, 1'b1, 1'b1, 1'b0, DC_NONE,     1'b0},
    '{CMD_TICK,   1'b1, 1'b0, 1'b0, 1'b0, DC_NONE,     1'b0},
    '{CMD_DONE,   1'b0, 1'b0, 1'b0, 1'b0, DC_NONE,     1'b0}
  };

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             in_valid_i;
  logic             in_ready_o;
  logic [1:0]       cmd_i;
  logic             switch_level_i;
  logic             enc_clk_i;
  logic             enc_dir_i;
  logic             out_valid_o;
  logic             out_ready_i;
  logic [2:0]       command_o;
  logic             track_mode_o;
  logic             psel;
  logic             penable;
  logic             pwrite;
  logic [AddrW-1:0] paddr;
  logic [DataW-1:0] pwdata;
  logic [DataW-1:0] prdata;
  logic             pready;

  // Predictor state: configuration plus a private copy of the block's state.
  cfg_t              dial_cfg;
  logic [7:0]        sw_hist;
  logic [7:0]        gest_timer;
  gesture_e          gest_state;
  logic              dial_mode;
  logic [1:0]        enc_pins;
  logic signed [7:0] step_count;
  logic              report_busy;

  dial_result_t expected_results[$];
  int           mismatch_count = 0;
  int           send_idle_pct  = 0;
  int           recv_stall_pct = 0;
  int           hold_off_asked = 0;
  logic         held_level     = 1'b1;

  dial_gesture_and_encoder_commands_unit i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .cmd_i          (cmd_i),
    .switch_level_i (switch_level_i),
    .enc_clk_i      (enc_clk_i),
    .enc_dir_i      (enc_dir_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .command_o      (command_o),
    .track_mode_o   (track_mode_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always #10 clk_i = ~clk_i;

  // Clamp a step count to the symmetric range the block keeps.
  function automatic logic signed [7:0] clamp_steps(input int v);
    if (v > 127) v = 127;
    if (v < -127) v = -127;
    return 8'(v);
  endfunction

  // Advance the predictor by one word and return the result word it causes.
  task automatic predict_dial_result(input logic [1:0] c, input logic lvl,
                                     input logic ck, input logic dr,
                                     output dial_result_t res);
    logic [7:0] masked;
    logic       press_hit;
    logic       rel_hit;
    logic [1:0] pins;
    res.command = DC_NONE;
    case (c)
      CMD_TICK: begin
        if (gest_timer != 8'd0) gest_timer--;
        sw_hist   = {sw_hist[6:0], lvl};
        masked    = sw_hist & dial_cfg.edge_mask;
        press_hit = (masked == dial_cfg.press_pattern);
        rel_hit   = (masked == dial_cfg.release_pattern);
        case (gest_state)
          GS_IDLE: begin
            if (press_hit) begin
              gest_state = GS_PRESSED;
              gest_timer = dial_cfg.click_ticks;
            end
          end
          GS_PRESSED: begin
            // A timeout under a busy report leaves the state alone; retry next tick.
            if (gest_timer == 8'd0) begin
              if (!report_busy) begin
                gest_state  = GS_HOLDING;
                gest_timer  = dial_cfg.hold_ticks;
                res.command = dial_mode ? DC_PLAY_PAUSE : DC_MUTE;
                report_busy = 1'b1;
              end
            end else if (rel_hit) begin
              gest_state = GS_RELEASED;
              gest_timer = dial_cfg.second_press_ticks;
            end
          end
          GS_RELEASED: begin
            if (gest_timer == 8'd0) gest_state = GS_IDLE;
            else if (press_hit) gest_state = GS_DOUBLE;
          end
          GS_DOUBLE: begin
            dial_mode  = ~dial_mode;
            gest_timer = dial_cfg.hold_ticks;
            gest_state = GS_WAIT_RELEASE;
          end
          GS_HOLDING: begin
            if (gest_timer == 8'd0) begin
              if (!report_busy) begin
                res.command = dial_mode ? DC_STOP : DC_PLAY_PAUSE;
                gest_state  = GS_WAIT_RELEASE;
                report_busy = 1'b1;
              end
            end else if (rel_hit) begin
              gest_state = GS_IDLE;
            end
          end
          GS_WAIT_RELEASE: begin
            if (rel_hit) gest_state = GS_IDLE;
          end
          default: begin
            gest_state = GS_IDLE;
          end
        endcase
        // Turn one pending step into a report once the link is free.
        if (!report_busy) begin
          if (step_count > 0) begin
            step_count  = clamp_steps(int'(step_count) - 1);
            res.command = dial_mode ? DC_NEXT : DC_VOL_UP;
            report_busy = 1'b1;
          end else if (step_count < 0) begin
            step_count  = clamp_steps(int'(step_count) + 1);
            res.command = dial_mode ? DC_PREVIOUS : DC_VOL_DOWN;
            report_busy = 1'b1;
          end
        end
      end
      CMD_EDGE: begin
        pins = {ck, dr};
        if (enc_pins == 2'b01 && pins == 2'b10) step_count = clamp_steps(int'(step_count) - 1);
        else if (enc_pins == 2'b00 && pins == 2'b11) step_count = clamp_steps(int'(step_count) + 1);
        enc_pins = pins;
      end
      CMD_DONE: begin
        report_busy = 1'b0;
      end
      default: begin
      end
    endcase
    res.track_mode = dial_mode;
  endtask

  // Offer one word, hold it until accepted, then queue its expected result.
  // Valid drops only for random idle gaps; otherwise back-to-back words see one assignment per step.
  task automatic send_dial_word(input logic [1:0] c, input logic lvl, input logic ck,
                                input logic dr, input logic typed = 1'b0,
                                input dial_cmd_e t_cmd = DC_NONE, input logic t_mode = 1'b0);
    dial_result_t res;
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_valid_i     <= 1'b1;
    cmd_i          <= c;
    switch_level_i <= lvl;
    enc_clk_i      <= ck;
    enc_dir_i      <= dr;
    do @(posedge clk_i); while (!in_ready_o);
    predict_dial_result(c, lvl, ck, dr, res);
    if (typed) begin
      res.command    = t_cmd;
      res.track_mode = t_mode;
    end
    expected_results.push_back(res);
  endtask

  // Hold until every queued result has come back, then let the pipeline settle.
  task automatic wait_drained();
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_dial_reg(input reg_idx_e idx, input logic [7:0] val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= AddrW'(4 * int'(idx));
    pwdata  <= DataW'(val);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_EDGE_MASK:          dial_cfg.edge_mask          = val;
      REG_PRESS_PATTERN:      dial_cfg.press_pattern      = val;
      REG_RELEASE_PATTERN:    dial_cfg.release_pattern    = val;
      REG_CLICK_TICKS:        dial_cfg.click_ticks        = val;
      REG_SECOND_PRESS_TICKS: dial_cfg.second_press_ticks = val;
      REG_HOLD_TICKS:         dial_cfg.hold_ticks         = val;
      default: begin
      end
    endcase
  endtask

  task automatic set_dial_cfg(input logic [7:0] mask, input logic [7:0] press_pat,
                              input logic [7:0] rel_pat, input logic [7:0] click,
                              input logic [7:0] second, input logic [7:0] hold);
    write_dial_reg(REG_EDGE_MASK, mask);
    write_dial_reg(REG_PRESS_PATTERN, press_pat);
    write_dial_reg(REG_RELEASE_PATTERN, rel_pat);
    write_dial_reg(REG_CLICK_TICKS, click);
    write_dial_reg(REG_SECOND_PRESS_TICKS, second);
    write_dial_reg(REG_HOLD_TICKS, hold);
  endtask

  // Mostly well-formed use: switch runs long enough to pass the debounce and the
  // gesture timers, whole detents, and frequent report-done words. The rest is
  // glitches, lone pin changes and unknown codes.
  task automatic run_dial_traffic(input int n_words, input int max_run);
    int   sent;
    int   pick;
    int   run_len;
    logic up;
    logic [1:0] noise_cmd;
    sent = 0;
    while (sent < n_words) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        held_level = ~held_level;
        run_len    = $urandom_range(1, max_run);
        repeat (run_len) begin
          send_dial_word(CMD_TICK, held_level, 1'($urandom), 1'($urandom));
          sent++;
          if ($urandom_range(0, 2) == 0) begin
            send_dial_word(CMD_DONE, 1'($urandom), 1'($urandom), 1'($urandom));
            sent++;
          end
        end
      end else if (pick < 65) begin
        up = 1'($urandom);
        send_dial_word(CMD_EDGE, 1'($urandom), 1'b0, ~up);
        send_dial_word(CMD_EDGE, 1'($urandom), 1'b1, up);
        sent += 2;
      end else if (pick < 80) begin
        send_dial_word(CMD_DONE, 1'($urandom), 1'($urandom), 1'($urandom));
        sent++;
      end else if (pick < 90) begin
        send_dial_word(CMD_TICK, ~held_level, 1'($urandom), 1'($urandom));
        sent++;
      end else begin
        noise_cmd = 2'($urandom);
        send_dial_word(noise_cmd, 1'($urandom), 1'($urandom), 1'($urandom));
        sent++;
      end
    end
  endtask

  // Spin one way with no ticks in between, past the saturation point.
  task automatic spin_to_limit();
    logic up;
    up = 1'($urandom);
    repeat (130) begin
      send_dial_word(CMD_EDGE, 1'($urandom), 1'b0, ~up);
      send_dial_word(CMD_EDGE, 1'($urandom), 1'b1, up);
    end
  endtask

  // Result sink: random stalls per phase, plus a long hold-off on request that
  // fills the block and pushes back on the input side.
  initial begin : result_sink
    int hold_off_left;
    int hold_off_served;
    hold_off_left   = 0;
    hold_off_served = 0;
    out_ready_i     = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_off_served != hold_off_asked) begin
        hold_off_served = hold_off_asked;
        hold_off_left   = HoldOffLen;
      end
      if (hold_off_left > 0) begin
        hold_off_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  // Compare each taken result word with the oldest expectation.
  always @(posedge clk_i) begin
    dial_result_t exp_res;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result word: command %0d mode %0d", command_o, track_mode_o);
      end else begin
        exp_res = expected_results.pop_front();
        if (command_o !== exp_res.command || track_mode_o !== exp_res.track_mode) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: expected command %0d mode %0d, got command %0d mode %0d",
                     exp_res.command, exp_res.track_mode, command_o, track_mode_o);
        end
      end
    end
  end

  // Stimulus and phase control.
  initial begin
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    cmd_i          = CMD_TICK;
    switch_level_i = 1'b1;
    enc_clk_i      = 1'b0;
    enc_dir_i      = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;

    dial_cfg    = '{EdgeMaskRst, PressPatRst, ReleasePatRst,
                    ClickTicksRst, SecondTicksRst, HoldTicksRst};
    sw_hist     = 8'hFF;
    gest_timer  = 8'd0;
    gest_state  = GS_IDLE;
    dial_mode   = 1'b0;
    enc_pins    = 2'b00;
    step_count  = 8'sd0;
    report_busy = 1'b0;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed words at reset configuration.
    foreach (DirectedRows[i]) begin
      send_dial_word(DirectedRows[i].cmd, DirectedRows[i].lvl, DirectedRows[i].ck,
                     DirectedRows[i].dr, DirectedRows[i].typed,
                     DirectedRows[i].exp_cmd, DirectedRows[i].exp_mode);
    end
    in_valid_i <= 1'b0;
    wait_drained();

    // Short timers, no idling; start with a long sink hold-off.
    set_dial_cfg(8'h0F, 8'h0C, 8'h03, 8'd5, 8'd4, 8'd10);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_off_asked++;
    run_dial_traffic(30, 14);
    in_valid_i <= 1'b0;
    wait_drained();

    // Two-bit debounce, idle sender.
    set_dial_cfg(8'h03, 8'h02, 8'h01, 8'd3, 8'd3, 8'd6);
    send_idle_pct  = 80;
    recv_stall_pct = 0;
    run_dial_traffic(30, 9);
    in_valid_i <= 1'b0;
    wait_drained();

    // Full-byte patterns, immediate click and longest windows; stalling sink.
    set_dial_cfg(8'hFF, 8'h00, 8'hFF, 8'd0, 8'd255, 8'd255);
    send_idle_pct  = 0;
    recv_stall_pct = 80;
    run_dial_traffic(30, 20);
    in_valid_i <= 1'b0;
    wait_drained();

    // Zero hold time, saturating spin, light idling on both sides.
    set_dial_cfg(8'hFF, 8'hF0, 8'h0F, 8'd8, 8'd6, 8'd0);
    send_idle_pct  = 15;
    recv_stall_pct = 15;
    run_dial_traffic(10, 12);
    spin_to_limit();
    run_dial_traffic(15, 12);
    in_valid_i <= 1'b0;
    wait_drained();

    // Empty mask: every tick matches both patterns.
    set_dial_cfg(8'h00, 8'h00, 8'h00, 8'd255, 8'd0, 8'd3);
    send_idle_pct  = 15;
    recv_stall_pct = 15;
    run_dial_traffic(30, 6);
    in_valid_i <= 1'b0;
    wait_drained();

    if (mismatch_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Hard stop in case the handshake hangs.
  initial begin
    #5000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
